// ===== sv/slcd_pkg.sv =====
// slcd_pkg: shared types, event codes and constants of the frame deframer
// no dependencies; imported by every module of the block

package slcd_pkg;

  localparam logic [7:0]  SYNC_BYTE      = 8'hAA;
  localparam logic [7:0]  REPLY_LEN      = 8'h06;
  localparam logic [15:0] MIN_FRAME_LEN  = 16'd4;
  localparam logic [15:0] MAX_LEN_RESET  = 16'd269;
  localparam logic [2:0]  REPLY_LAST_IDX = 3'd5;
  // sum of the fixed reply bytes AA 00 06 00
  localparam logic [7:0]  REPLY_FIXED_SUM = SYNC_BYTE + REPLY_LEN;

  localparam logic OP_BYTE  = 1'b0;
  localparam logic OP_REPLY = 1'b1;

  typedef enum logic [2:0] {
    EV_HUNT   = 3'd0,
    EV_ACCEPT = 3'd1,
    EV_GOOD   = 3'd2,
    EV_BADSUM = 3'd3,
    EV_BADLEN = 3'd4,
    EV_HALTED = 3'd5,
    EV_REPLY  = 3'd6
  } event_e;

  // one classified item travelling from front to back
  typedef struct packed {
    logic        is_reply;
    event_e      ev;
    logic [7:0]  value;
    logic [15:0] index;
  } slcd_cmd_t;

  // byte idx of the status reply AA 00 06 00 status sum
  function automatic logic [7:0] reply_byte(input logic [2:0] idx, input logic [7:0] status);
    logic [7:0] res;
    case (idx)
      3'd0: res = SYNC_BYTE;
      3'd1: res = 8'h00;
      3'd2: res = REPLY_LEN;
      3'd3: res = 8'h00;
      3'd4: res = status;
      default: res = REPLY_FIXED_SUM + status;
    endcase
    return res;
  endfunction

endpackage

// ===== sv/slcd_if.sv =====
// slcd_in_if / slcd_out_if: valid-ready channels of the deframer
// depends on nothing; payload widths follow the item fields

interface slcd_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] rx_byte;
  logic [7:0] reply_status;

  modport source (output valid, opcode, rx_byte, reply_status, input ready);
  modport sink   (input valid, opcode, rx_byte, reply_status, output ready);
endinterface

interface slcd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  event_res;
  logic [7:0]  byte_value;
  logic [15:0] byte_index;
  logic        last;

  modport source (output valid, event_res, byte_value, byte_index, last, input ready);
  modport sink   (input valid, event_res, byte_value, byte_index, last, output ready);
endinterface

// ===== sv/slcd_front.sv =====
// slcd_front: takes input transfers, runs the frame parser, emits commands
// depends on slcd_pkg and slcd_in_if

module slcd_front import slcd_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     max_len_i,
  slcd_in_if.sink         in_i,
  input  logic            full_i,
  output logic            push_o,
  output slcd_cmd_t       cmd_o
);

  logic [15:0] byte_count_q, byte_count_d;
  logic [15:0] frame_length_q, frame_length_d;
  logic [7:0]  running_sum_q, running_sum_d;
  logic        halted_q, halted_d;

  logic        accept;
  logic [15:0] len_full;
  logic        last_byte;

  assign in_i.ready = !full_i;
  assign accept     = in_i.valid && !full_i;
  assign len_full   = {frame_length_q[15:8], in_i.rx_byte};
  assign last_byte  = (({1'b0, byte_count_q} + 17'd1) >= {1'b0, frame_length_q});

  always_comb begin
    byte_count_d   = byte_count_q;
    frame_length_d = frame_length_q;
    running_sum_d  = running_sum_q;
    halted_d       = halted_q;
    push_o         = 1'b0;
    cmd_o.is_reply = 1'b0;
    cmd_o.ev       = EV_HUNT;
    cmd_o.value    = in_i.rx_byte;
    cmd_o.index    = byte_count_q;
    if (accept) begin
      push_o = 1'b1;
      if (in_i.opcode == OP_REPLY) begin
        cmd_o.is_reply = 1'b1;
        cmd_o.ev       = EV_REPLY;
        cmd_o.value    = in_i.reply_status;
        cmd_o.index    = 16'd0;
        halted_d       = 1'b0;
        byte_count_d   = 16'd0;
        running_sum_d  = 8'd0;
      end else if (halted_q) begin
        cmd_o.ev    = EV_HALTED;
        cmd_o.index = 16'd0;
      end else if (byte_count_q == 16'd0) begin
        if (in_i.rx_byte == SYNC_BYTE) begin
          cmd_o.ev      = EV_ACCEPT;
          running_sum_d = in_i.rx_byte;
          byte_count_d  = 16'd1;
        end else begin
          cmd_o.ev = EV_HUNT;
        end
      end else if (byte_count_q == 16'd1) begin
        cmd_o.ev       = EV_ACCEPT;
        frame_length_d = {in_i.rx_byte, 8'h00};
        running_sum_d  = running_sum_q + in_i.rx_byte;
        byte_count_d   = 16'd2;
      end else if (byte_count_q == 16'd2) begin
        frame_length_d = len_full;
        if (len_full > max_len_i || len_full < MIN_FRAME_LEN) begin
          cmd_o.ev     = EV_BADLEN;
          byte_count_d = 16'd0;
        end else begin
          cmd_o.ev      = EV_ACCEPT;
          running_sum_d = running_sum_q + in_i.rx_byte;
          byte_count_d  = 16'd3;
        end
      end else if (last_byte) begin
        if (in_i.rx_byte == running_sum_q) begin
          cmd_o.ev = EV_GOOD;
          halted_d = 1'b1;
        end else begin
          cmd_o.ev = EV_BADSUM;
        end
        byte_count_d = 16'd0;
      end else begin
        cmd_o.ev      = EV_ACCEPT;
        running_sum_d = running_sum_q + in_i.rx_byte;
        byte_count_d  = byte_count_q + 16'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q   <= 16'd0;
      frame_length_q <= 16'd0;
      running_sum_q  <= 8'd0;
      halted_q       <= 1'b0;
    end else begin
      byte_count_q   <= byte_count_d;
      frame_length_q <= frame_length_d;
      running_sum_q  <= running_sum_d;
      halted_q       <= halted_d;
    end
  end

endmodule

// ===== sv/slcd_queue.sv =====
// slcd_queue: short command fifo between parser front and emitter back
// depends on slcd_pkg for the command type

module slcd_queue import slcd_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  slcd_cmd_t  cmd_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       head_valid_o,
  output slcd_cmd_t  head_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  slcd_cmd_t         entries_q [DEPTH];
  logic [PW-1:0]     wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]     count_q;

  assign full_o       = (count_q == CW'(DEPTH));
  assign head_valid_o = (count_q != '0);
  assign head_o       = entries_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o) else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o) else $error("pop from empty queue");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== sv/slcd_back.sv =====
// slcd_back: expands queued commands into result transfers, output register
// depends on slcd_pkg and slcd_out_if

module slcd_back import slcd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  slcd_cmd_t  head_i,
  output logic       pop_o,
  slcd_out_if.source out_o
);

  logic        out_valid_q, out_valid_d;
  event_e      ev_q, ev_d;
  logic [7:0]  value_q, value_d;
  logic [15:0] index_q, index_d;
  logic        last_q, last_d;
  logic [2:0]  rep_cnt_q, rep_cnt_d;
  logic        load;

  // output register frees up when empty or being taken
  assign load = head_valid_i && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    ev_d        = ev_q;
    value_d     = value_q;
    index_d     = index_q;
    last_d      = last_q;
    rep_cnt_d   = rep_cnt_q;
    pop_o       = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (head_i.is_reply) begin
        ev_d    = EV_REPLY;
        value_d = reply_byte(rep_cnt_q, head_i.value);
        index_d = 16'(rep_cnt_q);
        last_d  = (rep_cnt_q == REPLY_LAST_IDX);
        if (rep_cnt_q == REPLY_LAST_IDX) begin
          rep_cnt_d = 3'd0;
          pop_o     = 1'b1;
        end else begin
          rep_cnt_d = rep_cnt_q + 3'd1;
        end
      end else begin
        ev_d    = head_i.ev;
        value_d = head_i.value;
        index_d = head_i.index;
        last_d  = 1'b1;
        pop_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      rep_cnt_q   <= 3'd0;
    end else begin
      out_valid_q <= out_valid_d;
      rep_cnt_q   <= rep_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q    <= ev_d;
    value_q <= value_d;
    index_q <= index_d;
    last_q  <= last_d;
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.event_res  = ev_q;
  assign out_o.byte_value = value_q;
  assign out_o.byte_index = index_q;
  assign out_o.last       = last_q;

  a_reply_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q != 3'd0 |-> head_valid_i && head_i.is_reply)
    else $error("reply count set without reply at queue head");
  a_reply_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q <= REPLY_LAST_IDX) else $error("reply count out of range");
  a_pop_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && last_q) else $error("pop without final result loaded");

endmodule

// ===== sv/sync_length_checksum_deframer_core.sv =====
// sync_length_checksum_deframer_core: top level of the frame deframer
// depends on slcd_pkg, slcd_if, slcd_front, slcd_queue, slcd_back
//
// channel   dir  handshake        payload
// in_i      in   valid/ready      opcode, rx_byte, reply_status
// out_o     out  valid/ready      event_res, byte_value, byte_index, last
// cfg       in   cfg_we_i only    cfg_wdata_i -> max_frame_length
//
// the parser takes one input transfer per cycle while the queue is not full; its
// command is written into the queue and then loaded from the queue head into the
// emitter output register; a reply command gives six result transfers, one per
// cycle while the output is ready, set by the single output register of the emitter
// the command queue lets the parser keep taking bytes while the output stalls,
// until its entries are used up; input ready drops only when the queue is full
// async active-low reset clears parser state, queue and output valid;
// max_frame_length resets to 269

module sync_length_checksum_deframer_core import slcd_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  slcd_in_if.sink     in_i,
  slcd_out_if.source  out_o
);

  // configuration register
  logic [15:0] max_len_q;

  // front to back command path
  logic      push;
  logic      full;
  logic      pop;
  logic      head_valid;
  slcd_cmd_t cmd;
  slcd_cmd_t head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= MAX_LEN_RESET;
    end else if (cfg_we_i) begin
      max_len_q <= cfg_wdata_i;
    end
  end

  // parser: classifies every byte and tracks the frame
  slcd_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .max_len_i (max_len_q),
    .in_i      (in_i),
    .full_i    (full),
    .push_o    (push),
    .cmd_o     (cmd)
  );

  // decouples parser from output backpressure
  slcd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .cmd_i        (cmd),
    .full_o       (full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // emitter: one result per command, six for a reply
  slcd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_o        (out_o)
  );

endmodule

// ===== test/slcd_tb_pkg.sv =====
`timescale 1ns / 1ps
// slcd_tb_pkg: expected-result predictor and result checker for the frame deframer bench
// depends on slcd_pkg for event codes and frame constants

package slcd_tb_pkg;
  import slcd_pkg::*;

  typedef struct {
    event_e      ev;
    logic [7:0]  value;
    logic [15:0] index;
    logic        last;
  } byte_result_t;

  class deframer_scoreboard;
    logic [15:0]  max_len;
    logic [15:0]  frame_pos;
    logic [15:0]  frame_len;
    logic [7:0]   frame_sum;
    logic         halted;
    byte_result_t expected_q[$];
    int unsigned  mismatches;

    function new();
      max_len    = MAX_LEN_RESET;
      frame_pos  = '0;
      frame_len  = '0;
      frame_sum  = '0;
      halted     = 1'b0;
      mismatches = 0;
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    // advance the frame state by one accepted transfer and queue what it yields
    function void note_item(logic op, logic [7:0] rx, logic [7:0] status);
      logic [7:0]  reply_bytes[6];
      logic [7:0]  reply_sum;
      logic [15:0] pos;
      event_e      ev;
      int          i;
      if (op == OP_REPLY) begin
        reply_bytes = '{SYNC_BYTE, 8'h00, REPLY_LEN, 8'h00, status, 8'h00};
        reply_sum = '0;
        for (i = 0; i < 5; i++) reply_sum = reply_sum + reply_bytes[i];
        reply_bytes[5] = reply_sum;
        for (i = 0; i < 6; i++) begin
          expected_q.push_back('{ev: EV_REPLY, value: reply_bytes[i], index: 16'(i),
                                 last: (i == 5)});
        end
        halted    = 1'b0;
        frame_pos = '0;
        frame_sum = '0;
        return;
      end
      if (halted) begin
        expected_q.push_back('{ev: EV_HALTED, value: rx, index: 16'd0, last: 1'b1});
        return;
      end
      pos = frame_pos;
      if (pos == 16'd0) begin
        if (rx != SYNC_BYTE) begin
          ev = EV_HUNT;
        end else begin
          ev        = EV_ACCEPT;
          frame_sum = rx;
          frame_pos = 16'd1;
        end
      end else if (pos == 16'd1) begin
        ev        = EV_ACCEPT;
        frame_len = {rx, 8'h00};
        frame_sum = frame_sum + rx;
        frame_pos = 16'd2;
      end else if (pos == 16'd2) begin
        frame_len = {frame_len[15:8], rx};
        if (frame_len > max_len || frame_len < MIN_FRAME_LEN) begin
          ev        = EV_BADLEN;
          frame_pos = '0;
        end else begin
          ev        = EV_ACCEPT;
          frame_sum = frame_sum + rx;
          frame_pos = 16'd3;
        end
      end else if (32'(pos) + 1 >= 32'(frame_len)) begin
        // checksum byte closes the frame either way
        if (rx == frame_sum) begin
          ev     = EV_GOOD;
          halted = 1'b1;
        end else begin
          ev = EV_BADSUM;
        end
        frame_pos = '0;
      end else begin
        ev        = EV_ACCEPT;
        frame_sum = frame_sum + rx;
        frame_pos = pos + 16'd1;
      end
      expected_q.push_back('{ev: ev, value: rx, index: pos, last: 1'b1});
    endfunction

    function void check_result(logic [2:0] ev, logic [7:0] value, logic [15:0] index,
                               logic last);
      byte_result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing expected: event %0d value %02h index %0d last %0b",
                   $time, ev, value, index, last);
        return;
      end
      want = expected_q.pop_front();
      if (3'(want.ev) !== ev || want.value !== value || want.index !== index ||
          want.last !== last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected event %0d value %02h index %0d last %0b, got %0d %02h %0d %0b",
                   $time, want.ev, want.value, want.index, want.last,
                   ev, value, index, last);
      end
    endfunction
  endclass

endpackage

// ===== test/sync_length_checksum_deframer_core_tb.sv =====
`timescale 1ns / 1ps
// sync_length_checksum_deframer_core_tb: frame, checksum and reply checks of the deframer
// depends on slcd_pkg, slcd_if, slcd_tb_pkg and the deframer core

module sync_length_checksum_deframer_core_tb;
  import slcd_pkg::*;
  import slcd_tb_pkg::*;

  localparam int unsigned LONG_HOLD    = 150;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned DRAIN_CYCLES = 12;

  typedef enum int {FR_GOOD, FR_BADSUM, FR_CUT} frame_kind_e;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [15:0] cfg_wdata_i;

  slcd_in_if  in_if ();
  slcd_out_if out_if ();

  sync_length_checksum_deframer_core u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  deframer_scoreboard sb;
  logic [15:0]        cur_max = MAX_LEN_RESET;
  int                 items_sent = 0;
  int unsigned        cycle_count = 0;
  bit                 send_burst = 1'b0;
  bit                 hold_req = 1'b0;

  always #2 clk_i = ~clk_i;

  // runaway guard
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sync_length_checksum_deframer_core_tb: errors");
      $finish;
    end
  end

  // result side: random stalls, occasional stall-free bursts, one long hold-off
  initial begin
    int          stall;
    int unsigned n_results;
    bit          recv_burst;
    n_results  = 0;
    recv_burst = 1'b0;
    out_if.ready <= 1'b0;
    do @(posedge clk_i); while (rst_ni !== 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        stall    = LONG_HOLD;
      end else begin
        stall = recv_burst ? 0 : $urandom_range(0, 4);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_if.valid && out_if.ready));
      sb.check_result(out_if.event_res, out_if.byte_value, out_if.byte_index, out_if.last);
      n_results++;
      if (n_results % 24 == 0) recv_burst = ($urandom_range(0, 3) == 0);
    end
  end

  // one input transfer; valid stays high when the next item follows with no gap
  task automatic push_item(input logic op, input logic [7:0] rx, input logic [7:0] status);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid        <= 1'b1;
    in_if.opcode       <= op;
    in_if.rx_byte      <= rx;
    in_if.reply_status <= status;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_item(op, rx, status);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] rx);
    push_item(OP_BYTE, rx, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_reply(input logic [7:0] status);
    push_item(OP_REPLY, 8'($urandom_range(0, 255)), status);
  endtask

  // header, body and checksum; stops after the header if the length gets rejected,
  // a cut frame is abandoned by a reply at body position cut
  task automatic send_frame(input int len, input frame_kind_e kind, input int cut);
    logic [15:0] len16;
    logic [7:0]  sum;
    logic [7:0]  b;
    int          i;
    len16 = len[15:0];
    sum   = SYNC_BYTE + len16[15:8] + len16[7:0];
    send_byte(SYNC_BYTE);
    send_byte(len16[15:8]);
    send_byte(len16[7:0]);
    if (len16 < MIN_FRAME_LEN || len16 > cur_max) return;
    for (i = 3; i < len - 1; i++) begin
      if (kind == FR_CUT && i == cut) begin
        send_reply(8'($urandom_range(0, 255)));
        return;
      end
      b   = 8'($urandom_range(0, 255));
      sum = sum + b;
      send_byte(b);
    end
    if (kind == FR_CUT) begin
      send_reply(8'($urandom_range(0, 255)));
    end else if (kind == FR_BADSUM) begin
      send_byte(sum ^ (8'd1 << $urandom_range(0, 7)));
    end else begin
      send_byte(sum);
    end
  endtask

  // mostly short frames, so the random part stays cheap
  function automatic int pick_len();
    int hi;
    hi = (cur_max < 16'd20) ? int'(cur_max) : 20;
    if (hi < 4) return 4;
    return $urandom_range(4, hi);
  endfunction

  task automatic random_traffic(input int n_items);
    int   goal;
    int   pick;
    int   len;
    int   n;
    int   i;
    logic saw_sync;
    logic [7:0] b;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      send_burst = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // good frame, a few ignored bytes while halted, then the re-arming reply
        send_frame(pick_len(), FR_GOOD, 0);
        n = $urandom_range(0, 2);
        for (i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
        send_reply(8'($urandom_range(0, 255)));
      end else if (pick < 65) begin
        send_frame(pick_len(), FR_BADSUM, 0);
      end else if (pick < 75) begin
        len = pick_len();
        send_frame(len, FR_CUT, $urandom_range(3, (len > 4) ? len - 1 : 3));
      end else if (pick < 85) begin
        // header with a length out of range
        if (cur_max == 16'hFFFF || $urandom_range(0, 1) == 0)
          len = $urandom_range(0, 3);
        else
          len = $urandom_range(int'(cur_max) + 1, 65535);
        send_frame(len, FR_GOOD, 0);
      end else begin
        // line noise; resync with a reply if a sync byte slipped in
        saw_sync = 1'b0;
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++) begin
          b = 8'($urandom_range(0, 255));
          if (b == SYNC_BYTE) saw_sync = 1'b1;
          send_byte(b);
        end
        if (saw_sync) send_reply(8'($urandom_range(0, 255)));
      end
    end
    send_burst = 1'b0;
  endtask

  // input goes quiet and every expected result drains before the block counts as idle
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_max_len(input logic [15:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.max_len = value;
    cur_max    = value;
  endtask

  initial begin
    sb = new();
    rst_ni             <= 1'b0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= '0;
    in_if.valid        <= 1'b0;
    in_if.opcode       <= OP_BYTE;
    in_if.rx_byte      <= '0;
    in_if.reply_status <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part at the reset maximum of 269
    send_byte(8'h00);                    // hunting discards
    send_byte(8'hFF);
    send_reply(8'h00);                   // reply with nothing to re-arm
    send_frame(4, FR_GOOD, 0);           // shortest legal frame, halts the receiver
    send_byte(SYNC_BYTE);                // ignored while halted
    send_reply(8'hFF);
    send_frame(5, FR_BADSUM, 0);
    send_frame(3, FR_GOOD, 0);           // length below the minimum
    send_frame(270, FR_GOOD, 0);         // one past the maximum
    send_frame(269, FR_CUT, 3);          // exactly the maximum, abandoned by a reply

    hold_req = 1'b1;                     // back-pressure long enough to fill the block
    random_traffic(40);

    write_max_len(16'd4);                // only four-byte frames pass
    random_traffic(15);

    write_max_len(16'hFFFF);
    send_frame(65535, FR_CUT, 8);        // largest header, abandoned early
    send_reply(8'($urandom_range(0, 255)));
    random_traffic(15);

    write_max_len(16'($urandom_range(5, 40)));
    random_traffic(30);

    write_max_len(16'd3);                // every length rejected
    random_traffic(8);

    settle();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("sync_length_checksum_deframer_core_tb: clean");
    end else begin
      $display("sync_length_checksum_deframer_core_tb: errors");
    end
    $finish;
  end

endmodule

// ===== sync_length_checksum_deframer_core.f =====
sv/slcd_pkg.sv
sv/slcd_if.sv
sv/slcd_front.sv
sv/slcd_queue.sv
sv/slcd_back.sv
sv/sync_length_checksum_deframer_core.sv
test/slcd_tb_pkg.sv
test/sync_length_checksum_deframer_core_tb.sv
